// File: design/brq_pkg.sv
// ----------------------------------------------------------------------------
// brq_pkg
// Shared constants and types of the bitrate admission queue.
// ----------------------------------------------------------------------------
package brq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = AW + 1;

  localparam int HDR_W  = 43;
  localparam int DESC_W = 32;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_REJECT   = 3'd1;
  localparam logic [2:0] ST_BITRATE  = 3'd2;
  localparam logic [2:0] ST_DEQUEUED = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam logic [1:0] POS_FIRST = 2'd0;
  localparam logic [1:0] POS_LAST  = 2'd2;
  localparam logic [1:0] POS_SOLO  = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic        scan;
    logic [15:0] packet_handle;
    logic [15:0] packet_length;
    logic        udp_flag;
    logic [31:0] msg_number;
    logic [7:0]  prio_level;
    logic [1:0]  position;
    logic [31:0] pkt_bitrate;
  } cmd_t;

  typedef struct packed {
    logic [31:0] bandwidth;
    logic [23:0] byte_limit;
    logic [8:0]  packet_limit;
  } cfg_t;

endpackage

// File: design/brq_ram.sv
// ----------------------------------------------------------------------------
// brq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module brq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/brq_front.sv
// ----------------------------------------------------------------------------
// brq_front
// Accept input beats, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module brq_front
  import brq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,
  input  logic         s_tuser,
  output logic         cq_valid,
  output cmd_t         cq_data,
  input  logic         cq_pop
);

  cmd_t       slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  cmd_t       c;
  logic       push;

  always_comb begin
    c.cmd           = s_tuser;
    c.packet_handle = s_tdata[15:0];
    c.packet_length = s_tdata[31:16];
    c.udp_flag      = s_tdata[32];
    c.msg_number    = s_tdata[64:33];
    c.prio_level    = s_tdata[72:65];
    c.position      = s_tdata[74:73];
    c.pkt_bitrate   = s_tdata[107:76];
    c.scan          = s_tdata[32] && s_tdata[75] &&
                      (s_tdata[74:73] == POS_LAST || s_tdata[74:73] == POS_SOLO);
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign cq_valid = (fill != 2'd0);
  assign cq_data  = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= c;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (cq_pop) begin
        rp <= ~rp;
      end
      if (push && !cq_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && cq_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// File: design/brq_back.sv
// ----------------------------------------------------------------------------
// brq_back
// Carry out enqueue, dequeue and stale message scans on the ring store.
// ----------------------------------------------------------------------------
module brq_back
  import brq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        cq_valid,
  input  cmd_t        cq_data,
  output logic        cq_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,
  output logic [2:0]  m_tuser
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DQ   = 3'd1;
  localparam logic [2:0] S_A_RD = 3'd2;
  localparam logic [2:0] S_A_EV = 3'd3;
  localparam logic [2:0] S_C_RD = 3'd4;
  localparam logic [2:0] S_C_EV = 3'd5;
  localparam logic [2:0] S_B_RD = 3'd6;
  localparam logic [2:0] S_B_EV = 3'd7;

  logic [2:0]  state;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [23:0] bytes;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] w;
  logic [CW-1:0] removed;
  logic [1:0]  ends;
  logic [31:0] m;
  logic [7:0]  p;
  logic [31:0] msg_q;
  logic [2:0]  st_q;

  logic [2:0]  o_status;
  logic [15:0] o_handle;
  logic [15:0] o_len;
  logic [8:0]  o_rem;
  logic [8:0]  o_qp;
  logic [23:0] o_qb;

  logic              h_we;
  logic [AW-1:0]     h_wa;
  logic [AW-1:0]     h_ra;
  logic [HDR_W-1:0]  h_wd;
  logic [HDR_W-1:0]  h_rd;
  logic [DESC_W-1:0] d_wd;
  logic [DESC_W-1:0] d_rd;
  logic              f_we;
  logic [AW-1:0]     f_wa;
  logic              f_wd;
  logic              f_rd;

  logic          out_free;
  logic          start;
  logic [24:0]   nbytes;
  logic [CW:0]   npkts;
  logic          ok;
  logic          store;
  logic          cand;
  logic          match;
  logic          solo_hit;
  logic          end_hit;
  logic [1:0]    ends_new;
  logic          j_done;
  logic          i_last;
  logic [CW-1:0] i_inc;
  logic          emit;

  assign out_free = !m_tvalid || m_tready;
  assign start    = (state == S_IDLE) && cq_valid && out_free;
  assign cq_pop   = start;

  assign nbytes = {1'b0, bytes} + {9'd0, cq_data.packet_length};
  assign npkts  = {1'b0, count} + {{CW{1'b0}}, 1'b1};
  assign ok     = (count != CW'(QUEUE_DEPTH)) && !nbytes[24] &&
                  (cfg.byte_limit == 24'd0 || nbytes[23:0] <= cfg.byte_limit) &&
                  (cfg.packet_limit == 9'd0 || npkts <= (CW+1)'(cfg.packet_limit));
  assign store  = !cq_data.udp_flag || (cfg.bandwidth >= cq_data.pkt_bitrate);

  assign cand     = h_rd[42] && (h_rd[9:2] >= p) && (h_rd[41:10] < m);
  assign match    = (h_rd[41:10] == msg_q);
  assign solo_hit = match && (h_rd[1:0] == POS_SOLO);
  assign end_hit  = match && (h_rd[1:0] == POS_FIRST || h_rd[1:0] == POS_LAST);
  assign ends_new = (end_hit && ends != 2'd2) ? ends + 2'd1 : ends;
  assign j_done   = solo_hit || (j + CW'(1) == count);
  assign i_inc    = i + CW'(1);
  assign i_last   = (i_inc == count);

  assign emit = (start && ((cq_data.cmd == CMD_DEQ) ? (count == '0) :
                           (!ok || !(cq_data.scan && (store || count != '0))))) ||
                (state == S_DQ) || (state == S_B_EV && i_last);

  always_comb begin
    h_we = 1'b0;
    h_wa = head + count[AW-1:0];
    h_wd = {cq_data.udp_flag, cq_data.msg_number, cq_data.prio_level, cq_data.position};
    d_wd = {cq_data.packet_handle, cq_data.packet_length};
    f_we = 1'b0;
    f_wa = i[AW-1:0];
    f_wd = 1'b0;
    case (state)
      S_IDLE: h_ra = head;
      S_C_RD: h_ra = head + j[AW-1:0];
      default: h_ra = head + i[AW-1:0];
    endcase
    case (state)
      S_IDLE: begin
        h_we = start && cq_data.cmd == CMD_ENQ && ok && store;
      end
      S_A_EV: begin
        f_we = !cand;
      end
      S_C_EV: begin
        f_we = j_done;
        f_wd = solo_hit || ends_new == 2'd2;
      end
      S_B_EV: begin
        h_we = !f_rd;
        h_wa = head + w[AW-1:0];
        h_wd = h_rd;
        d_wd = d_rd;
      end
      default: begin
      end
    endcase
  end

  brq_ram #(.WIDTH(HDR_W), .DEPTH(QUEUE_DEPTH)) u_hdr (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );

  brq_ram #(.WIDTH(DESC_W), .DEPTH(QUEUE_DEPTH)) u_desc (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(d_wd), .raddr(h_ra), .rdata(d_rd)
  );

  brq_ram #(.WIDTH(1), .DEPTH(QUEUE_DEPTH)) u_flag (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(i[AW-1:0]), .rdata(f_rd)
  );

  assign m_tuser = o_status;
  assign m_tdata = {6'd0, o_qb, o_qp, o_rem, o_len, o_handle};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      bytes    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            o_handle <= 16'd0;
            o_len    <= 16'd0;
            o_rem    <= 9'd0;
            i        <= '0;
            removed  <= '0;
            m        <= cq_data.msg_number;
            p        <= cq_data.prio_level;
            if (cq_data.cmd == CMD_DEQ) begin
              if (count == '0) begin
                o_status <= ST_EMPTY;
                o_qp     <= count;
                o_qb     <= bytes;
              end else begin
                state <= S_DQ;
              end
            end else if (!ok) begin
              o_status <= ST_REJECT;
              o_qp     <= count;
              o_qb     <= bytes;
            end else begin
              st_q     <= store ? ST_STORED : ST_BITRATE;
              o_status <= store ? ST_STORED : ST_BITRATE;
              if (store) begin
                count <= npkts[CW-1:0];
                bytes <= nbytes[23:0];
              end
              if (cq_data.scan && (store || count != '0)) begin
                state <= S_A_RD;
              end else begin
                o_qp     <= store ? npkts[CW-1:0] : count;
                o_qb     <= store ? nbytes[23:0] : bytes;
              end
            end
          end
        end
        S_DQ: begin
          o_status <= ST_DEQUEUED;
          o_handle <= d_rd[31:16];
          o_len    <= d_rd[15:0];
          o_qp     <= count - CW'(1);
          o_qb     <= bytes - {8'd0, d_rd[15:0]};
          count    <= count - CW'(1);
          bytes    <= bytes - {8'd0, d_rd[15:0]};
          head     <= head + AW'(1);
          state    <= S_IDLE;
        end
        S_A_RD: begin
          state <= S_A_EV;
        end
        S_A_EV: begin
          if (cand) begin
            msg_q <= h_rd[41:10];
            j     <= '0;
            ends  <= 2'd0;
            state <= S_C_RD;
          end else if (i_last) begin
            i     <= '0;
            w     <= '0;
            state <= S_B_RD;
          end else begin
            i     <= i_inc;
            state <= S_A_RD;
          end
        end
        S_C_RD: begin
          state <= S_C_EV;
        end
        S_C_EV: begin
          ends <= ends_new;
          if (!j_done) begin
            j     <= j + CW'(1);
            state <= S_C_RD;
          end else if (i_last) begin
            i     <= '0;
            w     <= '0;
            state <= S_B_RD;
          end else begin
            i     <= i_inc;
            state <= S_A_RD;
          end
        end
        S_B_RD: begin
          state <= S_B_EV;
        end
        S_B_EV: begin
          if (f_rd) begin
            bytes   <= bytes - {8'd0, d_rd[15:0]};
            removed <= removed + CW'(1);
          end else begin
            w <= w + CW'(1);
          end
          i <= i_inc;
          if (i_last) begin
            count    <= f_rd ? w : w + CW'(1);
            o_status <= st_q;
            o_rem    <= f_rd ? removed + CW'(1) : removed;
            o_qp     <= f_rd ? w : w + CW'(1);
            o_qb     <= f_rd ? bytes - {8'd0, d_rd[15:0]} : bytes;
            state    <= S_IDLE;
          end else begin
            state <= S_B_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/bitrate_admit_stale_drop_queue_top.sv
// ----------------------------------------------------------------------------
// bitrate_admit_stale_drop_queue_top
// Packet descriptor queue with bitrate admission and stale message removal.
// ----------------------------------------------------------------------------
// Usage: each input beat on s_* carries one command (tuser 0 enqueue,
// 1 dequeue) and yields exactly one result beat on m_*, in order. Commands
// enter a two-entry queue and are executed one at a time by a sequencer
// working on a 256-entry ring store kept in single-port-read RAMs.
// A preempting UDP enqueue that ends a message scans the store: a first pass
// over every entry, an inner sweep that checks the message completeness of
// every candidate found, and a compaction pass over every entry that drops
// the stale ones.
// Configuration is to be written over APB while the block is idle; the block
// does not enforce it. Reset empties the queue and clears the state, counters
// and config; the store needs no sweep. When m_tready stays low the result
// holds in its register, the sequencer waits before starting the next
// command, and s_tready drops once the command queue is full.
// ----------------------------------------------------------------------------
module bitrate_admit_stale_drop_queue_top
  import brq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // packet_handle, packet_length, udp_flag, msg_number, prio_level,
  // position, preempt_flag, pkt_bitrate
  input  logic [111:0] s_tdata,
  // cmd
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_handle, out_length, stale_removed, queued_packets, queued_bytes
  output logic [79:0]  m_tdata,
  // status
  output logic [2:0]   m_tuser
);

  localparam logic [1:0] REG_BANDWIDTH = 2'd0;
  localparam logic [1:0] REG_BYTE_LIM  = 2'd1;
  localparam logic [1:0] REG_PKT_LIM   = 2'd2;

  cfg_t cfg;
  logic cq_valid;
  cmd_t cq_data;
  logic cq_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BANDWIDTH: cfg.bandwidth    <= pwdata;
        REG_BYTE_LIM:  cfg.byte_limit   <= pwdata[23:0];
        REG_PKT_LIM:   cfg.packet_limit <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BANDWIDTH: prdata = cfg.bandwidth;
      REG_BYTE_LIM:  prdata = {8'd0, cfg.byte_limit};
      REG_PKT_LIM:   prdata = {23'd0, cfg.packet_limit};
      default:       prdata = 32'd0;
    endcase
  end

  brq_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cq_valid(cq_valid), .cq_data(cq_data), .cq_pop(cq_pop)
  );

  brq_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .cq_valid(cq_valid), .cq_data(cq_data), .cq_pop(cq_pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitrate admission queue with stale message
// removal. A behavioral model of the queue predicts every result beat. It
// runs directed cases, a full-store fill and drain, and three random phases
// with message-shaped traffic under changing idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import brq_pkg::*;

  localparam logic [3:0] REG_BANDWIDTH = 4'd0;
  localparam logic [3:0] REG_BYTE_LIMIT = 4'd4;
  localparam logic [3:0] REG_PACKET_LIMIT = 4'd8;
  localparam logic [1:0] POS_MIDDLE = 2'd1;
  localparam int STALL_LIMIT = 400000;

  typedef struct {
    logic        cmd;
    logic [15:0] handle;
    logic [15:0] length;
    logic        udp;
    logic [31:0] msg;
    logic [7:0]  prio;
    logic [1:0]  pos;
    logic        preempt;
    logic [31:0] rate;
  } pkt_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] handle;
    logic [15:0] length;
    logic [8:0]  removed;
    logic [8:0]  packets;
    logic [23:0] bytes;
  } verdict_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 0;
  logic s_tready;
  logic [111:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [79:0] m_tdata;
  logic [2:0] m_tuser;

  int src_idle_pct = 15;
  int dst_stall_pct = 54;
  int mismatches = 0;
  int quiet_cycles = 0;

  logic [31:0] bw_reg;
  logic [23:0] byte_lim;
  logic [8:0]  pkt_lim;
  pkt_t queue_mdl[$];
  int unsigned byte_total;
  verdict_t pending[$];

  logic [31:0] msg_seq;

  bitrate_admit_stale_drop_queue_top uut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= dst_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit msg_complete(logic [31:0] msg);
    int ends;
    ends = 0;
    foreach (queue_mdl[j]) begin
      if (queue_mdl[j].msg == msg) begin
        if (queue_mdl[j].pos == POS_SOLO) return 1;
        if (queue_mdl[j].pos == POS_FIRST || queue_mdl[j].pos == POS_LAST) ends++;
      end
    end
    return ends >= 2;
  endfunction

  function automatic verdict_t queue_predict(pkt_t p);
    verdict_t v;
    pkt_t kept[$];
    bit drop[$];
    int unsigned nbytes;
    bit ok;
    v = '{default: '0};
    if (p.cmd == CMD_DEQ) begin
      if (queue_mdl.size() == 0) begin
        v.status = ST_EMPTY;
      end else begin
        v.handle = queue_mdl[0].handle;
        v.length = queue_mdl[0].length;
        byte_total -= queue_mdl[0].length;
        void'(queue_mdl.pop_front());
        v.status = ST_DEQUEUED;
      end
    end else begin
      nbytes = byte_total + p.length;
      ok = queue_mdl.size() < QUEUE_DEPTH && nbytes <= 24'hFFFFFF &&
           (byte_lim == 0 || nbytes <= byte_lim) &&
           (pkt_lim == 0 || queue_mdl.size() + 1 <= pkt_lim);
      if (!ok) begin
        v.status = ST_REJECT;
      end else begin
        if (!p.udp || bw_reg >= p.rate) begin
          queue_mdl.push_back(p);
          byte_total = nbytes;
          v.status = ST_STORED;
        end else begin
          v.status = ST_BITRATE;
        end
        if (p.udp && p.preempt && (p.pos == POS_LAST || p.pos == POS_SOLO)) begin
          foreach (queue_mdl[i])
            drop.push_back(queue_mdl[i].udp && queue_mdl[i].prio >= p.prio &&
                           queue_mdl[i].msg < p.msg && msg_complete(queue_mdl[i].msg));
          foreach (queue_mdl[i]) begin
            if (drop[i]) begin
              byte_total -= queue_mdl[i].length;
              v.removed++;
            end else begin
              kept.push_back(queue_mdl[i]);
            end
          end
          queue_mdl = kept;
        end
      end
    end
    v.packets = 9'(queue_mdl.size());
    v.bytes = 24'(byte_total);
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        $error("result beat with no expectation: status %0d", m_tuser);
        mismatches++;
      end else begin
        exp_v = pending.pop_front();
        if (m_tuser != exp_v.status) begin
          $error("status exp %0d got %0d", exp_v.status, m_tuser);
          mismatches++;
        end
        if (m_tdata[15:0] != exp_v.handle) begin
          $error("out_handle exp %0h got %0h", exp_v.handle, m_tdata[15:0]);
          mismatches++;
        end
        if (m_tdata[31:16] != exp_v.length) begin
          $error("out_length exp %0h got %0h", exp_v.length, m_tdata[31:16]);
          mismatches++;
        end
        if (m_tdata[40:32] != exp_v.removed) begin
          $error("stale_removed exp %0d got %0d", exp_v.removed, m_tdata[40:32]);
          mismatches++;
        end
        if (m_tdata[49:41] != exp_v.packets) begin
          $error("queued_packets exp %0d got %0d", exp_v.packets, m_tdata[49:41]);
          mismatches++;
        end
        if (m_tdata[73:50] != exp_v.bytes) begin
          $error("queued_bytes exp %0h got %0h", exp_v.bytes, m_tdata[73:50]);
          mismatches++;
        end
      end
    end
  end

  task automatic send_beat(pkt_t p);
    int gap;
    gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= p.cmd;
    s_tdata <= {4'b0, p.rate, p.preempt, p.pos, p.prio, p.msg, p.udp, p.length,
                p.handle};
    do @(posedge clk); while (!s_tready);
    pending.push_back(queue_predict(p));
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [31:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (addr)
      REG_BANDWIDTH:  bw_reg = val;
      REG_BYTE_LIMIT: byte_lim = val[23:0];
      default:        pkt_lim = val[8:0];
    endcase
  endtask

  task automatic set_limits(logic [31:0] bw, logic [23:0] bl, logic [8:0] pl);
    wait_idle();
    reg_write(REG_BANDWIDTH, bw);
    reg_write(REG_BYTE_LIMIT, {8'b0, bl});
    reg_write(REG_PACKET_LIMIT, {23'b0, pl});
  endtask

  function automatic pkt_t mk(logic cmd, logic udp, logic [31:0] msg, logic [7:0] prio,
                              logic [1:0] pos, logic preempt, logic [31:0] rate,
                              logic [15:0] length);
    pkt_t p;
    p.cmd = cmd;
    p.handle = 16'($urandom_range(16'hFFFF));
    p.length = length;
    p.udp = udp;
    p.msg = msg;
    p.prio = prio;
    p.pos = pos;
    p.preempt = preempt;
    p.rate = rate;
    return p;
  endfunction

  task automatic test_directed();
    set_limits(32'd1000, 24'd0, 9'd0);
    send_beat(mk(CMD_DEQ, 0, 0, 0, 0, 0, 0, 0));
    send_beat(mk(CMD_ENQ, 0, 32'd1, 8'd0, POS_SOLO, 1, 32'hFFFFFFFF, 16'd0));
    send_beat(mk(CMD_ENQ, 1, 32'd5, 8'd3, POS_FIRST, 0, 32'd1000, 16'd10));
    send_beat(mk(CMD_ENQ, 1, 32'd5, 8'd3, POS_MIDDLE, 0, 32'd0, 16'd20));
    send_beat(mk(CMD_ENQ, 1, 32'd5, 8'd3, POS_LAST, 0, 32'd1001, 16'd30));
    send_beat(mk(CMD_ENQ, 1, 32'd5, 8'd4, POS_LAST, 0, 32'd10, 16'd40));
    send_beat(mk(CMD_ENQ, 1, 32'd6, 8'd9, POS_SOLO, 0, 32'd10, 16'd5));
    send_beat(mk(CMD_ENQ, 1, 32'd7, 8'd2, POS_FIRST, 0, 32'd10, 16'd5));
    send_beat(mk(CMD_ENQ, 1, 32'd8, 8'd1, POS_FIRST, 0, 32'd10, 16'd7));
    send_beat(mk(CMD_ENQ, 1, 32'd8, 8'd1, POS_FIRST, 0, 32'd10, 16'd7));
    send_beat(mk(CMD_ENQ, 0, 32'd10, 8'd3, POS_SOLO, 1, 32'd10, 16'd1));
    send_beat(mk(CMD_ENQ, 1, 32'd10, 8'd3, POS_SOLO, 1, 32'd5000, 16'd1));
    send_beat(mk(CMD_ENQ, 1, 32'hFFFFFFFF, 8'd0, POS_LAST, 1, 32'd1, 16'd3));
    send_beat(mk(CMD_DEQ, 0, 0, 0, 0, 0, 0, 0));
    set_limits(32'hFFFFFFFF, 24'd100, 9'd3);
    send_beat(mk(CMD_ENQ, 1, 32'd20, 8'hFF, POS_SOLO, 1, 32'hFFFFFFFF, 16'd101));
    send_beat(mk(CMD_ENQ, 1, 32'd20, 8'hFF, POS_SOLO, 0, 32'hFFFFFFFF, 16'd50));
    send_beat(mk(CMD_ENQ, 0, 32'd21, 8'd0, POS_SOLO, 0, 32'd0, 16'd50));
    send_beat(mk(CMD_ENQ, 0, 32'd22, 8'd0, POS_SOLO, 0, 32'd0, 16'd0));
    send_beat(mk(CMD_ENQ, 0, 32'd23, 8'd0, POS_SOLO, 0, 32'd0, 16'd0));
    set_limits(32'd0, 24'hFFFFFF, 9'd256);
    send_beat(mk(CMD_ENQ, 1, 32'd30, 8'd0, POS_SOLO, 1, 32'd0, 16'd1));
    repeat (8) send_beat(mk(CMD_DEQ, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_full_store();
    set_limits(32'hFFFFFFFF, 24'd0, 9'd0);
    repeat (QUEUE_DEPTH + 1)
      send_beat(mk(CMD_ENQ, 0, $urandom, 8'($urandom_range(255)), 2'($urandom_range(3)),
                   1'($urandom_range(1)), $urandom, 16'hFFFF));
    repeat (QUEUE_DEPTH + 1) send_beat(mk(CMD_DEQ, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int idle_src, int idle_dst, int count);
    pkt_t p;
    logic [31:0] bw;
    int parts, sent;
    bw = $urandom_range(1000, 3000);
    set_limits(bw, ($urandom_range(1)) ? 24'd0 : 24'($urandom_range(2000, 200000)),
               9'($urandom_range(4, 24)));
    src_idle_pct = idle_src;
    dst_stall_pct = idle_dst;
    msg_seq = $urandom;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        p = mk(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, 8'($urandom),
               2'($urandom), 1'($urandom_range(1)), $urandom, 16'($urandom));
        send_beat(p);
        sent++;
      end else begin
        msg_seq = msg_seq + $urandom_range(1, 3);
        parts = $urandom_range(0, 3);
        for (int k = 0; k <= parts; k++) begin
          p = mk(CMD_ENQ, $urandom_range(99) < 80, msg_seq, 8'($urandom_range(7)),
                 (parts == 0) ? POS_SOLO : (k == 0) ? POS_FIRST :
                 (k == parts) ? POS_LAST : POS_MIDDLE,
                 1'($urandom_range(1)), $urandom_range(bw - 500, bw + 200),
                 16'($urandom_range(1, 3000)));
          send_beat(p);
          sent++;
          if ($urandom_range(99) < 30) begin
            send_beat(mk(CMD_DEQ, 0, 0, 0, 0, 0, 0, 0));
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    bw_reg = '0;
    byte_lim = '0;
    pkt_lim = '0;
    byte_total = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random(15, 54, 200);
    test_random(54, 15, 200);
    test_random(0, 0, 200);
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
